[src/ebcpu_pkg.sv]
// ebcpu_pkg: opcode and branch condition codes, field widths and constants
// for the 8-bit cpu execute step; no dependencies
`timescale 1ns / 1ps

package ebcpu_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned PC_W   = 10;
    localparam int unsigned RIDX_W = 4;
    localparam int unsigned INSN_W = 16;
    localparam int unsigned NREGS  = 16;

    localparam logic [PC_W-1:0] PC_MAX = 10'h3FF;

    typedef enum logic [3:0] {
        OP_NOP = 4'd0,
        OP_HLT = 4'd1,
        OP_ADD = 4'd2,
        OP_SUB = 4'd3,
        OP_NOR = 4'd4,
        OP_AND = 4'd5,
        OP_XOR = 4'd6,
        OP_RSH = 4'd7,
        OP_LDI = 4'd8,
        OP_ADI = 4'd9,
        OP_JMP = 4'd10,
        OP_BRH = 4'd11,
        OP_CAL = 4'd12,
        OP_RET = 4'd13
    } opcode_t;

    typedef enum logic [1:0] {
        COND_ZERO      = 2'd0,
        COND_NOT_ZERO  = 2'd1,
        COND_CARRY     = 2'd2,
        COND_NOT_CARRY = 2'd3
    } cond_t;

endpackage

[src/eight_bit_cpu_execute_step.sv]
// eight_bit_cpu_execute_step: execute stage of a small 8-bit cpu with
// register file, flags, program counter and return stack
// depends on ebcpu_pkg
`timescale 1ns / 1ps

// Usage
//   s_ channel: one 16-bit instruction word per transaction (s_valid/s_ready).
//   m_ channel: one result per instruction: next pc, halt, register write
//   (enable, index, value), flags after the instruction and stack fault.
//   An accepted instruction passes the operand stage, then the result
//   register. Throughput: one instruction per cycle while m_ready is high;
//   the register file is read as the operand stage loads (registered read with
//   bypass from the instruction retiring in the same cycle); execution and
//   all state updates happen as the result register loads.
//   The return stack keeps its top two entries in registers; deeper entries
//   live in a single-port-write memory whose registered read always holds
//   the entry needed by the next return.
//   Reset (aresetn low, synchronous): registers read as zero, flags and pc
//   clear, stack empties, both channels go idle. No clearing pass is needed.
//   Stalls: when m_ready is low the result register holds; the execute stage
//   holds its instruction, and s_ready drops once both stages are full.
//   Register r0 always reads as zero; writes to it are reported but dropped.
module eight_bit_cpu_execute_step #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_instruction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_next_pc,
    output logic        m_halted,
    output logic        m_reg_write_enable,
    output logic [3:0]  m_reg_write_index,
    output logic [7:0]  m_reg_write_value,
    output logic        m_zero_out,
    output logic        m_carry_out,
    output logic        m_stack_fault
);

    localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned DW = ebcpu_pkg::DATA_W;
    localparam int unsigned PW = ebcpu_pkg::PC_W;
    localparam int unsigned RW = ebcpu_pkg::RIDX_W;

    // handshake control
    logic s_fire, ex_fire, out_free;
    logic ex_valid_reg, ex_valid_next;
    logic m_valid_reg, m_valid_next;

    // operand stage
    logic [ebcpu_pkg::INSN_W-1:0] insn_reg;
    logic [DW-1:0] a_mem_reg, b_mem_reg, a_alt_reg, b_alt_reg;
    logic a_use_mem_reg, b_use_mem_reg;
    logic [DW-1:0] rf_mem [ebcpu_pkg::NREGS];
    logic [ebcpu_pkg::NREGS-1:0] rf_vld_reg;
    logic [RW-1:0] s_ra, s_rb;
    logic fwd_a, fwd_b;

    // architectural state
    logic [PW-1:0] pc_reg, pc_next;
    logic zero_reg, zero_next, carry_reg, carry_next;
    logic [LW-1:0] level_reg, level_next;
    logic [PW-1:0] tos_reg, tos_next, below_reg;
    logic [PW-1:0] stk_mem [STACK_DEPTH];
    logic push_en, pop_en, stk_wr_en;
    logic [LW-1:0] level_m1, level_m3;

    // execute stage
    ebcpu_pkg::opcode_t op;
    logic [DW-1:0] a_val, b_val, imm;
    logic [RW-1:0] ra, rc;
    logic [PW-1:0] addr, pc_inc;
    logic [DW:0] sum;
    logic [DW-1:0] wr_value;
    logic [RW-1:0] wr_index;
    logic wr_en, halted, fault, take;

    // result register
    logic [PW-1:0] out_pc_reg;
    logic out_halted_reg, out_we_reg, out_zero_reg, out_carry_reg, out_fault_reg;
    logic [RW-1:0] out_idx_reg;
    logic [DW-1:0] out_val_reg;

    // handshake
    assign out_free      = !m_valid_reg || m_ready;
    assign ex_fire       = ex_valid_reg && out_free;
    assign s_ready       = !ex_valid_reg || out_free;
    assign s_fire        = s_valid && s_ready;
    assign ex_valid_next = s_fire || (ex_valid_reg && !ex_fire);
    assign m_valid_next  = ex_fire || (m_valid_reg && !m_ready);

    // operand read addresses and bypass from the retiring instruction
    assign s_ra  = s_instruction[11:8];
    assign s_rb  = s_instruction[7:4];
    assign fwd_a = ex_fire && wr_en && (wr_index != '0) && (wr_index == s_ra);
    assign fwd_b = ex_fire && wr_en && (wr_index != '0) && (wr_index == s_rb);

    // operand selection
    assign a_val = a_use_mem_reg ? a_mem_reg : a_alt_reg;
    assign b_val = b_use_mem_reg ? b_mem_reg : b_alt_reg;

    // instruction fields
    assign op     = ebcpu_pkg::opcode_t'(insn_reg[15:12]);
    assign ra     = insn_reg[11:8];
    assign rc     = insn_reg[3:0];
    assign imm    = insn_reg[7:0];
    assign addr   = insn_reg[PW-1:0];
    assign pc_inc = pc_reg + PW'(1);

    // execute: alu, flags, branch, write back
    always_comb begin
        sum        = '0;
        wr_value   = '0;
        wr_index   = '0;
        wr_en      = 1'b0;
        halted     = 1'b0;
        take       = 1'b0;
        zero_next  = zero_reg;
        carry_next = carry_reg;
        pc_next    = pc_reg;
        case (op)
            ebcpu_pkg::OP_NOP: begin
                pc_next = pc_inc;
            end
            ebcpu_pkg::OP_HLT: begin
                halted = 1'b1;
            end
            ebcpu_pkg::OP_ADD: begin
                sum        = {1'b0, a_val} + {1'b0, b_val};
                wr_value   = sum[DW-1:0];
                carry_next = sum[DW];
                wr_index   = rc;
                wr_en      = 1'b1;
                zero_next  = (wr_value == '0);
            end
            ebcpu_pkg::OP_SUB: begin
                wr_value   = a_val - b_val;
                carry_next = (a_val < b_val);
                wr_index   = rc;
                wr_en      = 1'b1;
                zero_next  = (wr_value == '0);
            end
            ebcpu_pkg::OP_NOR: begin
                wr_value   = ~(a_val | b_val);
                carry_next = 1'b0;
                wr_index   = rc;
                wr_en      = 1'b1;
                zero_next  = (wr_value == '0);
            end
            ebcpu_pkg::OP_AND: begin
                wr_value   = a_val & b_val;
                carry_next = 1'b0;
                wr_index   = rc;
                wr_en      = 1'b1;
                zero_next  = (wr_value == '0);
            end
            ebcpu_pkg::OP_XOR: begin
                wr_value   = a_val ^ b_val;
                carry_next = 1'b0;
                wr_index   = rc;
                wr_en      = 1'b1;
                zero_next  = (wr_value == '0);
            end
            ebcpu_pkg::OP_RSH: begin
                wr_value   = a_val >> 1;
                carry_next = a_val[0];
                wr_index   = rc;
                wr_en      = 1'b1;
                zero_next  = (wr_value == '0);
            end
            ebcpu_pkg::OP_LDI: begin
                wr_value   = imm;
                zero_next  = 1'b0;
                carry_next = 1'b0;
                wr_index   = ra;
                wr_en      = 1'b1;
            end
            ebcpu_pkg::OP_ADI: begin
                sum        = {1'b0, a_val} + {1'b0, imm};
                wr_value   = sum[DW-1:0];
                carry_next = sum[DW];
                wr_index   = ra;
                wr_en      = 1'b1;
                zero_next  = (wr_value == '0);
            end
            ebcpu_pkg::OP_JMP: begin
                pc_next = addr;
            end
            ebcpu_pkg::OP_BRH: begin
                case (ebcpu_pkg::cond_t'(insn_reg[11:10]))
                    ebcpu_pkg::COND_ZERO:      take = zero_reg;
                    ebcpu_pkg::COND_NOT_ZERO:  take = !zero_reg;
                    ebcpu_pkg::COND_CARRY:     take = carry_reg;
                    ebcpu_pkg::COND_NOT_CARRY: take = !carry_reg;
                    default:                   take = 1'b0;
                endcase
                pc_next = take ? addr : pc_inc;
            end
            ebcpu_pkg::OP_CAL: begin
                pc_next = addr;
            end
            ebcpu_pkg::OP_RET: begin
                pc_next = (level_reg == '0) ? ebcpu_pkg::PC_MAX : tos_reg + PW'(1);
            end
            default: begin
                pc_next = pc_reg;
            end
        endcase
    end

    // return stack control: top two entries in registers, the rest in memory
    assign push_en   = (op == ebcpu_pkg::OP_CAL) && (level_reg < LW'(STACK_DEPTH));
    assign pop_en    = (op == ebcpu_pkg::OP_RET) && (level_reg != '0);
    assign fault     = ((op == ebcpu_pkg::OP_CAL) && !push_en)
                    || ((op == ebcpu_pkg::OP_RET) && !pop_en);
    assign level_m1  = level_reg - LW'(1);
    assign level_m3  = level_reg - LW'(3);
    assign stk_wr_en = ex_fire && push_en && (level_reg != '0);

    always_comb begin
        level_next = level_reg;
        tos_next   = tos_reg;
        if (push_en) begin
            level_next = level_reg + LW'(1);
            tos_next   = pc_reg;
        end else if (pop_en) begin
            level_next = level_m1;
            tos_next   = below_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pc_reg       <= '0;
            zero_reg     <= 1'b0;
            carry_reg    <= 1'b0;
            level_reg    <= '0;
            rf_vld_reg   <= '0;
        end else begin
            ex_valid_reg <= ex_valid_next;
            m_valid_reg  <= m_valid_next;
            if (ex_fire) begin
                pc_reg    <= pc_next;
                zero_reg  <= zero_next;
                carry_reg <= carry_next;
                level_reg <= level_next;
                if (wr_en && (wr_index != '0)) begin
                    rf_vld_reg[wr_index] <= 1'b1;
                end
            end
        end
    end

    // register file memory: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (ex_fire && wr_en && (wr_index != '0)) begin
            rf_mem[wr_index] <= wr_value;
        end
        if (s_fire) begin
            a_mem_reg <= rf_mem[s_ra];
            b_mem_reg <= rf_mem[s_rb];
        end
    end

    // operand stage payload: instruction and operand source
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            insn_reg      <= s_instruction;
            a_use_mem_reg <= (s_ra != '0) && rf_vld_reg[s_ra] && !fwd_a;
            b_use_mem_reg <= (s_rb != '0) && rf_vld_reg[s_rb] && !fwd_b;
            a_alt_reg     <= fwd_a ? wr_value : '0;
            b_alt_reg     <= fwd_b ? wr_value : '0;
        end
    end

    // return stack memory and top-of-stack registers
    always_ff @(posedge aclk) begin
        if (stk_wr_en) begin
            stk_mem[level_m1[AW-1:0]] <= tos_reg;
        end
        if (ex_fire && pop_en) begin
            below_reg <= stk_mem[level_m3[AW-1:0]];
        end else if (ex_fire && push_en) begin
            below_reg <= tos_reg;
        end
        if (ex_fire) begin
            tos_reg <= tos_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (ex_fire) begin
            out_pc_reg     <= pc_next;
            out_halted_reg <= halted;
            out_we_reg     <= wr_en;
            out_idx_reg    <= wr_index;
            out_val_reg    <= wr_value;
            out_zero_reg   <= zero_next;
            out_carry_reg  <= carry_next;
            out_fault_reg  <= fault;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_next_pc          = out_pc_reg;
    assign m_halted           = out_halted_reg;
    assign m_reg_write_enable = out_we_reg;
    assign m_reg_write_index  = out_idx_reg;
    assign m_reg_write_value  = out_val_reg;
    assign m_zero_out         = out_zero_reg;
    assign m_carry_out        = out_carry_reg;
    assign m_stack_fault      = out_fault_reg;

`ifndef NO_ASSERTIONS
    // stack level never passes its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LW'(STACK_DEPTH))
        else $error("return stack level beyond depth");

    // input stalls only when both stages are occupied and output blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (ex_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled with room in the pipeline");

    // no register write means zero index and value in the result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !out_we_reg) |-> (out_idx_reg == '0 && out_val_reg == '0))
        else $error("write fields set without write enable");

    // return from an empty stack lands at the top address with a fault
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ex_fire && op == ebcpu_pkg::OP_RET && level_reg == '0)
        |=> (pc_reg == ebcpu_pkg::PC_MAX && out_fault_reg && level_reg == '0))
        else $error("empty-stack return mishandled");

    // halt leaves the program counter unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ex_fire && op == ebcpu_pkg::OP_HLT) |=> (pc_reg == $past(pc_reg)))
        else $error("program counter moved on halt");
`endif

endmodule
